// File: rtl/tcle_pkg.sv
// Shared types and constants for the text console line editor.
// No dependencies; used by every module of the block.
package tcle_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int PO_W    = 7;
   localparam int TYPE_W  = 3;
   localparam int CSR_IW  = 1;
   localparam int CSR_DW  = 8;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0020;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [PO_W-1:0]   PO_RESET   = 7'd2;
   localparam logic [ATTR_W-1:0] DA_RESET   = 8'd7;
   localparam int                TAB_SPACES = 5;

   localparam logic [CSR_IW-1:0] CSR_PROMPT_OFFSET = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_DEFAULT_ATTR  = 1'd1;

   localparam logic [TYPE_W-1:0] REQ_PUT   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_LEFT  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_RIGHT = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_BS     = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL     = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;

   typedef enum logic [3:0] {
      OP_INSERT, OP_BACKSPACE, OP_NEWLINE, OP_RETURN, OP_TAB,
      OP_LEFT, OP_RIGHT, OP_CLEAR, OP_READ, OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CELL_W-1:0]   cell_word;
      logic [POS_W-1:0]    idx;
   } item_type;

endpackage

// File: rtl/tcle_front.sv
// Front end: takes request beats and decodes them into editor operations.
// Depends on tcle_pkg.
module tcle_front (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tcle_pkg::TYPE_W-1:0] req_type,
   input  logic [tcle_pkg::CHAR_W-1:0] char_code,
   input  logic [tcle_pkg::ATTR_W-1:0] attribute,
   input  logic [tcle_pkg::POS_W-1:0]  cell_index,
   input  logic [tcle_pkg::ATTR_W-1:0] default_attribute,
   input  logic                        hold,
   input  logic                        q_full,
   output logic                        push,
   output tcle_pkg::item_type          item
);

   logic [tcle_pkg::ATTR_W-1:0] attr_eff;

   assign attr_eff   = (attribute != '0) ? attribute : default_attribute;
   assign req_tready = !q_full && !hold;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      item.cell_word = {attr_eff, char_code};
      item.idx  = cell_index;
      item.op   = tcle_pkg::OP_NOP;
      case (req_type)
         tcle_pkg::REQ_PUT: begin
            case (char_code)
               tcle_pkg::CH_BS:  item.op = tcle_pkg::OP_BACKSPACE;
               tcle_pkg::CH_NL:  item.op = tcle_pkg::OP_NEWLINE;
               tcle_pkg::CH_CR:  item.op = tcle_pkg::OP_RETURN;
               tcle_pkg::CH_TAB: begin
                  item.op   = tcle_pkg::OP_TAB;
                  item.cell_word = {default_attribute, tcle_pkg::SPACE_CHAR};
               end
               default:          item.op = tcle_pkg::OP_INSERT;
            endcase
         end
         tcle_pkg::REQ_LEFT:  item.op = tcle_pkg::OP_LEFT;
         tcle_pkg::REQ_RIGHT: item.op = tcle_pkg::OP_RIGHT;
         tcle_pkg::REQ_CLEAR: item.op = tcle_pkg::OP_CLEAR;
         tcle_pkg::REQ_READ:  item.op = tcle_pkg::OP_READ;
         default:             item.op = tcle_pkg::OP_NOP;
      endcase
   end

endmodule

// File: rtl/tcle_queue.sv
// Two-entry operation queue between front end and sequencer.
// Depends on tcle_pkg.
module tcle_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcle_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output tcle_pkg::item_type pop_item
);

   tcle_pkg::item_type slot_ff [2];
   logic               wr_ff, rd_ff;
   logic [1:0]         count_ff;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_item = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// File: rtl/tcle_back.sv
// Sequencer: owns the screen store and carries out one operation at a time,
// moving one cell per cycle, then registers the response. Depends on tcle_pkg.
module tcle_back #(
   parameter int COLUMNS = tcle_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcle_pkg::ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcle_pkg::PO_W-1:0]   prompt_offset,
   input  logic                        q_valid,
   input  tcle_pkg::item_type          q_item,
   output logic                        q_pop,
   output logic                        init_busy,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tcle_pkg::POS_W-1:0]  cursor_pos,
   output logic [tcle_pkg::POS_W-1:0]  end_pos,
   output logic [tcle_pkg::CELL_W-1:0] cell_value
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int W     = $clog2(CELLS + 2 * COLUMNS + 128);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_EXEC, S_COPY, S_FILL, S_WRITE, S_SCROLL, S_BLANK,
      S_LINE, S_NEXT, S_READ, S_RESP
   } state_type;

   state_type                   state_ff, after_ff;
   tcle_pkg::op_type            op_ff;
   logic [tcle_pkg::CELL_W-1:0] cell_ff, fval_ff, rdata_ff;
   logic [tcle_pkg::POS_W-1:0]  idx_ff;
   logic [2:0]                  tab_ff;
   logic [W-1:0]                end_ff, cur_ff, lim_ff, rs_ff;
   logic [AW-1:0]               src_ff, dst_ff;
   logic [CW-1:0]               cnt_ff;
   logic                        up_ff, pend_ff, zero_ff;
   logic                        rsp_valid_ff;
   logic [tcle_pkg::POS_W-1:0]  rsp_cur_ff, rsp_end_ff;
   logic [tcle_pkg::CELL_W-1:0] rsp_cell_ff;

   logic [tcle_pkg::CELL_W-1:0] mem [CELLS];
   logic                        we, re;
   logic [AW-1:0]               waddr, raddr;
   logic [tcle_pkg::CELL_W-1:0] wdata;
   logic                        idx_ok;
   logic                        out_free;

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign init_busy  = (state_ff == S_INIT) ||
                       ((state_ff == S_FILL) && (after_ff == S_IDLE));
   assign rsp_tvalid = rsp_valid_ff;
   assign cursor_pos = rsp_cur_ff;
   assign end_pos    = rsp_end_ff;
   assign cell_value = rsp_cell_ff;
   assign idx_ok     = 32'(idx_ff) < 32'(CELLS);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      we    = 1'b0;
      re    = 1'b0;
      waddr = dst_ff;
      raddr = src_ff;
      wdata = rdata_ff;
      case (state_ff)
         S_COPY: begin
            re = (cnt_ff != '0);
            we = pend_ff;
         end
         S_FILL: begin
            we    = 1'b1;
            wdata = fval_ff;
         end
         S_WRITE: begin
            we    = 1'b1;
            waddr = AW'(cur_ff);
            wdata = cell_ff;
         end
         S_READ: begin
            re    = 1'b1;
            raddr = (op_ff == tcle_pkg::OP_READ) ? AW'(idx_ff) : AW'(cur_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         after_ff     <= S_IDLE;
         end_ff       <= '0;
         cur_ff       <= '0;
         lim_ff       <= W'(tcle_pkg::PO_RESET);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         tab_ff       <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_INIT: begin
               dst_ff   <= '0;
               cnt_ff   <= CW'(CELLS);
               fval_ff  <= tcle_pkg::BLANK_CELL;
               after_ff <= S_IDLE;
               state_ff <= S_FILL;
            end
            S_IDLE: begin
               if (q_valid) begin
                  op_ff    <= q_item.op;
                  cell_ff  <= q_item.cell_word;
                  idx_ff   <= q_item.idx;
                  tab_ff   <= '0;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_READ;
               pend_ff  <= 1'b0;
               case (op_ff)
                  tcle_pkg::OP_INSERT, tcle_pkg::OP_TAB: begin
                     state_ff <= S_WRITE;
                     if (cur_ff < end_ff) begin
                        src_ff   <= AW'(end_ff - 1'b1);
                        dst_ff   <= AW'(end_ff);
                        cnt_ff   <= CW'(end_ff - cur_ff);
                        up_ff    <= 1'b0;
                        after_ff <= S_WRITE;
                        state_ff <= S_COPY;
                     end
                  end
                  tcle_pkg::OP_BACKSPACE: begin
                     if (cur_ff > lim_ff && cur_ff != '0) begin
                        src_ff   <= AW'(cur_ff);
                        dst_ff   <= AW'(cur_ff - 1'b1);
                        cnt_ff   <= CW'(end_ff - cur_ff + 1'b1);
                        up_ff    <= 1'b1;
                        after_ff <= S_READ;
                        state_ff <= S_COPY;
                        cur_ff   <= cur_ff - 1'b1;
                        end_ff   <= end_ff - 1'b1;
                     end
                  end
                  tcle_pkg::OP_NEWLINE: begin
                     end_ff   <= end_ff + W'(COLUMNS);
                     rs_ff    <= '0;
                     state_ff <= S_LINE;
                  end
                  tcle_pkg::OP_RETURN: begin
                     rs_ff    <= '0;
                     state_ff <= S_LINE;
                  end
                  tcle_pkg::OP_LEFT: begin
                     if (cur_ff > lim_ff && cur_ff != '0) cur_ff <= cur_ff - 1'b1;
                  end
                  tcle_pkg::OP_RIGHT: begin
                     if (cur_ff < end_ff) cur_ff <= cur_ff + 1'b1;
                  end
                  tcle_pkg::OP_CLEAR: begin
                     cur_ff <= end_ff;
                     if (end_ff > lim_ff) begin
                        dst_ff   <= AW'(lim_ff);
                        cnt_ff   <= CW'(end_ff - lim_ff);
                        fval_ff  <= tcle_pkg::CLEAR_CELL;
                        after_ff <= S_READ;
                        state_ff <= S_FILL;
                        end_ff   <= lim_ff;
                        cur_ff   <= lim_ff;
                     end
                  end
                  default: ;
               endcase
            end
            S_COPY: begin
               if (cnt_ff != '0) begin
                  src_ff <= up_ff ? src_ff + 1'b1 : src_ff - 1'b1;
                  cnt_ff <= cnt_ff - 1'b1;
               end
               pend_ff <= (cnt_ff != '0);
               if (pend_ff) dst_ff <= up_ff ? dst_ff + 1'b1 : dst_ff - 1'b1;
               if (cnt_ff == '0 && !pend_ff) state_ff <= after_ff;
            end
            S_FILL: begin
               dst_ff <= dst_ff + 1'b1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) state_ff <= after_ff;
            end
            S_WRITE: begin
               end_ff <= end_ff + 1'b1;
               cur_ff <= cur_ff + 1'b1;
               state_ff <= ((end_ff + 1'b1) == W'(CELLS)) ? S_SCROLL : S_NEXT;
            end
            S_SCROLL: begin
               src_ff   <= AW'(COLUMNS);
               dst_ff   <= '0;
               cnt_ff   <= CW'(CELLS - COLUMNS);
               up_ff    <= 1'b1;
               pend_ff  <= 1'b0;
               after_ff <= S_BLANK;
               state_ff <= S_COPY;
               end_ff   <= end_ff - W'(COLUMNS);
               cur_ff   <= end_ff - W'(COLUMNS);
               lim_ff   <= end_ff - W'(COLUMNS) + W'(prompt_offset);
            end
            S_BLANK: begin
               dst_ff   <= AW'(CELLS - COLUMNS);
               cnt_ff   <= CW'(COLUMNS);
               fval_ff  <= tcle_pkg::BLANK_CELL;
               after_ff <= S_NEXT;
               state_ff <= S_FILL;
            end
            S_LINE: begin
               if ((rs_ff + W'(COLUMNS)) <= end_ff) begin
                  rs_ff <= rs_ff + W'(COLUMNS);
               end else begin
                  end_ff   <= rs_ff;
                  cur_ff   <= rs_ff;
                  lim_ff   <= rs_ff + W'(prompt_offset);
                  state_ff <= (rs_ff >= W'(CELLS)) ? S_SCROLL : S_READ;
               end
            end
            S_NEXT: begin
               state_ff <= S_READ;
               if (op_ff == tcle_pkg::OP_TAB) begin
                  if (tab_ff == 3'(tcle_pkg::TAB_SPACES - 1)) begin
                     cur_ff <= end_ff;
                  end else begin
                     tab_ff   <= tab_ff + 1'b1;
                     state_ff <= S_EXEC;
                  end
               end
            end
            S_READ: begin
               zero_ff  <= (op_ff == tcle_pkg::OP_READ) && !idx_ok;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cur_ff   <= tcle_pkg::POS_W'(cur_ff);
                  rsp_end_ff   <= tcle_pkg::POS_W'(end_ff);
                  rsp_cell_ff  <= zero_ff ? '0 : rdata_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/text_console_line_editor.sv
// Top level of the text console line editor: configuration registers,
// front end, operation queue and sequencer. Depends on tcle_pkg and submodules.
//
// Usage: requests arrive on req_ (tuser = request type, tdata = character,
// attribute, cell index); one response beat per request leaves on rsp_
// (tdata = cursor, end position, cell). The user writes registers through csr_
// only while no request is in flight; the block itself does not enforce this.
// After reset the screen store is blanked, one cell a cycle, and req_tready
// stays low until the blanking is done.
// An insert or delete shifts each cell from the cursor up to the end position,
// a scroll moves the screen up one row and blanks the last row, a tab is five
// inserts and a newline searches the rows for the new line start. Everything
// runs through the single-port-per-direction screen store, one cell per cycle.
// A two-beat queue lets the front accept while the sequencer works; a held
// response register keeps its beat until rsp_tready, and the sequencer waits.
module text_console_line_editor #(
   parameter int COLUMNS = tcle_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcle_pkg::ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,  // char_code, attribute, cell_index
   input  logic [2:0]                  req_tuser,  // req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,  // cursor_pos, end_pos, cell_value
   input  logic                        csr_we,
   input  logic [tcle_pkg::CSR_IW-1:0] csr_index,
   input  logic [tcle_pkg::CSR_DW-1:0] csr_wdata
);

   logic [tcle_pkg::PO_W-1:0]   po_ff;
   logic [tcle_pkg::ATTR_W-1:0] da_ff;
   logic                        hold, q_full, push, pop, q_valid;
   tcle_pkg::item_type          f_item, q_item;
   logic [tcle_pkg::POS_W-1:0]  cur_o, end_o;
   logic [tcle_pkg::CELL_W-1:0] cell_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         po_ff <= tcle_pkg::PO_RESET;
         da_ff <= tcle_pkg::DA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tcle_pkg::CSR_PROMPT_OFFSET: po_ff <= tcle_pkg::PO_W'(csr_wdata);
            tcle_pkg::CSR_DEFAULT_ATTR:  da_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tcle_front u_front (
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_type          (req_tuser),
      .char_code         (req_tdata[7:0]),
      .attribute         (req_tdata[15:8]),
      .cell_index        (req_tdata[26:16]),
      .default_attribute (da_ff),
      .hold              (hold),
      .q_full            (q_full),
      .push              (push),
      .item              (f_item)
   );

   tcle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (pop),
      .valid     (q_valid),
      .pop_item  (q_item)
   );

   tcle_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .prompt_offset (po_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (pop),
      .init_busy     (hold),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .cursor_pos    (cur_o),
      .end_pos       (end_o),
      .cell_value    (cell_o)
   );

   assign rsp_tdata = {2'b00, cell_o, end_o, cur_o};

endmodule

// File: rtl/tcle_checker.sv
// Port-level checks for the text console line editor, bound to the top level.
// Depends on tcle_pkg.
module tcle_checker #(
   parameter int COLUMNS = tcle_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcle_pkg::ROWS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [39:0]                 rsp_tdata
);

   localparam int CELLS = COLUMNS * ROWS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("beat offered straight after reset");

   a_cursor_le_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:0] <= rsp_tdata[21:11])
      else $error("cursor beyond end position");

   a_end_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[21:11]) < 32'(CELLS))
      else $error("end position off screen");

endmodule

bind text_console_line_editor tcle_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcle_checker (.*);

// File: sim/tcle_checker.sv
// Scoreboard for the text console line editor: watches the request, response
// and register ports, keeps its own copy of the screen and compares beats.
// Depends on tcle_pkg.
module tcle_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [tcle_pkg::CSR_IW-1:0] csr_index,
   input  logic [tcle_pkg::CSR_DW-1:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          scroll_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS  = tcle_pkg::COLUMNS_DEF;
   localparam int CELLS = tcle_pkg::COLUMNS_DEF * tcle_pkg::ROWS_DEF;

   typedef struct packed {
      logic [tcle_pkg::CELL_W-1:0] cell_val;
      logic [tcle_pkg::POS_W-1:0]  end_p;
      logic [tcle_pkg::POS_W-1:0]  cursor;
   } view_type;

   logic [tcle_pkg::CELL_W-1:0] screen [CELLS];
   int unsigned end_at, cursor, limit;
   logic [tcle_pkg::PO_W-1:0]   prompt;
   logic [tcle_pkg::ATTR_W-1:0] def_attr;
   view_type screen_views [$];

   task automatic scroll_if_full();
      if (end_at < CELLS) return;
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = tcle_pkg::BLANK_CELL;
      end_at -= COLS;
      cursor = end_at;
      limit  = end_at + prompt;
      scroll_count++;
   endtask

   task automatic insert_cell(logic [tcle_pkg::CELL_W-1:0] v);
      if (cursor < CELLS) begin
         if (end_at > cursor && end_at < CELLS)
            for (int i = end_at; i > cursor; i--) screen[i] = screen[i - 1];
         screen[cursor] = v;
      end
      end_at++;
      cursor++;
      scroll_if_full();
   endtask

   task automatic line_start();
      end_at -= end_at % COLS;
      cursor = end_at;
      limit  = end_at + prompt;
   endtask

   task automatic edit_screen(logic [2:0] kind, logic [7:0] ch, logic [7:0] attr,
                              logic [10:0] idx);
      logic [7:0] a;
      int unsigned at;
      view_type v;
      a = (attr != 0) ? attr : def_attr;
      case (kind)
         tcle_pkg::REQ_PUT: begin
            case (ch)
               tcle_pkg::CH_BS: begin
                  if (!(cursor <= limit || cursor == 0)) begin
                     at = cursor - 1;
                     if (at < CELLS) screen[at] = {a, tcle_pkg::SPACE_CHAR};
                     if (end_at > at && end_at < CELLS)
                        for (int i = at; i < end_at; i++) screen[i] = screen[i + 1];
                     cursor--;
                     if (end_at > 0) end_at--;
                  end
               end
               tcle_pkg::CH_NL: begin
                  end_at += COLS;
                  line_start();
               end
               tcle_pkg::CH_CR: line_start();
               tcle_pkg::CH_TAB: begin
                  for (int k = 0; k < tcle_pkg::TAB_SPACES; k++)
                     insert_cell({def_attr, tcle_pkg::SPACE_CHAR});
                  cursor = end_at;
               end
               default: insert_cell({a, ch});
            endcase
            scroll_if_full();
         end
         tcle_pkg::REQ_LEFT:  if (cursor > limit && cursor > 0) cursor--;
         tcle_pkg::REQ_RIGHT: if (cursor < end_at) cursor++;
         tcle_pkg::REQ_CLEAR: begin
            while (end_at > limit) begin
               end_at--;
               if (end_at < CELLS) screen[end_at] = tcle_pkg::CLEAR_CELL;
            end
            cursor = end_at;
         end
         default: ;
      endcase
      v.cursor = cursor[tcle_pkg::POS_W-1:0];
      v.end_p  = end_at[tcle_pkg::POS_W-1:0];
      if (kind == tcle_pkg::REQ_READ) v.cell_val = (idx < CELLS) ? screen[idx] : '0;
      else v.cell_val = (cursor < CELLS) ? screen[cursor] : '0;
      screen_views.push_back(v);
   endtask

   initial begin
      fail_count = 0;
      scroll_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      view_type got, want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) screen[i] = tcle_pkg::BLANK_CELL;
         prompt = tcle_pkg::PO_RESET;
         def_attr = tcle_pkg::DA_RESET;
         end_at = 0;
         cursor = 0;
         limit = tcle_pkg::PO_RESET;
         screen_views.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == tcle_pkg::CSR_PROMPT_OFFSET)
               prompt = csr_wdata[tcle_pkg::PO_W-1:0];
            else if (csr_index == tcle_pkg::CSR_DEFAULT_ATTR) def_attr = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[37:0];
            if (screen_views.size() == 0) begin
               $error("response beat with nothing expected: %h", got);
               fail_count++;
            end else begin
               want = screen_views.pop_front();
               if (got.cursor !== want.cursor) begin
                  $error("cursor_pos expected %0d got %0d", want.cursor, got.cursor);
                  fail_count++;
               end
               if (got.end_p !== want.end_p) begin
                  $error("end_pos expected %0d got %0d", want.end_p, got.end_p);
                  fail_count++;
               end
               if (got.cell_val !== want.cell_val) begin
                  $error("cell_value expected %h got %h", want.cell_val, got.cell_val);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            edit_screen(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[26:16]);
      end
      pending = screen_views.size();
   end

endmodule

// File: sim/tb.sv
// Top of the line editor testbench: clock, reset, request and register
// stimulus with random idling, and the verdict. Depends on tcle_pkg,
// tcle_scoreboard and text_console_line_editor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 20_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [tcle_pkg::CSR_IW-1:0] csr_index = '0;
   logic [tcle_pkg::CSR_DW-1:0] csr_wdata = '0;
   int fail_count, pending, scroll_count;
   int sent = 0;
   int cycles = 0;
   bit calm = 1'b0;

   text_console_line_editor dut (.*);

   tcle_scoreboard chk (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response back-pressure in bursts
   always @(negedge clock) begin
      int n;
      if (reset) rsp_tready <= 1'b0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         n = $urandom_range(1, 13);
         repeat (n - 1) @(negedge clock);
      end else rsp_tready <= 1'b1;
   end

   task automatic send_key(logic [2:0] kind, logic [7:0] ch, logic [7:0] attr,
                           logic [10:0] idx);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, idx, attr, ch};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   task automatic set_regs(logic [6:0] po, logic [7:0] da);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= tcle_pkg::CSR_PROMPT_OFFSET;
      csr_wdata <= {1'b0, po};
      @(negedge clock);
      csr_index <= tcle_pkg::CSR_DEFAULT_ATTR;
      csr_wdata <= da;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_keys(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55)
            send_key(tcle_pkg::REQ_PUT, 8'($urandom_range(32, 126)), 8'($urandom),
                     11'($urandom));
         else if (r < 60)
            send_key(tcle_pkg::REQ_PUT, 8'($urandom), 8'($urandom), 11'($urandom));
         else if (r < 68)
            send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_BS, 8'($urandom), 11'($urandom));
         else if (r < 72)
            send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_NL, 8'($urandom), 11'($urandom));
         else if (r < 74)
            send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_CR, 8'($urandom), 11'($urandom));
         else if (r < 77)
            send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_TAB, 8'($urandom), 11'($urandom));
         else if (r < 82)
            send_key(tcle_pkg::REQ_LEFT, 8'($urandom), 8'($urandom), 11'($urandom));
         else if (r < 87)
            send_key(tcle_pkg::REQ_RIGHT, 8'($urandom), 8'($urandom), 11'($urandom));
         else if (r < 89)
            send_key(tcle_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
         else if (r < 96)
            send_key(tcle_pkg::REQ_READ, 8'($urandom), 8'($urandom), 11'($urandom));
         else if (r < 98) send_key(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                                   11'($urandom));
         else
            // run of newlines to push the end past the last row
            repeat ($urandom_range(10, 26))
               send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_NL, 8'd0, 11'd0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_BS, 8'd0, 11'd0);   // backspace below limit
      send_key(tcle_pkg::REQ_LEFT, 8'd0, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_RIGHT, 8'd0, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, 8'h41, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, 8'h00, 8'hff, 11'd0);
      send_key(tcle_pkg::REQ_PUT, 8'hff, 8'h5a, 11'd0);
      send_key(tcle_pkg::REQ_PUT, 8'h42, 8'h1e, 11'd0);
      send_key(tcle_pkg::REQ_LEFT, 8'd0, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_LEFT, 8'd0, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, 8'h43, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_BS, 8'h33, 11'd0);
      send_key(tcle_pkg::REQ_RIGHT, 8'd0, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_TAB, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_READ, 8'd0, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_READ, 8'd0, 8'd0, 11'd1999);
      send_key(tcle_pkg::REQ_READ, 8'hff, 8'hff, 11'd2047);
      send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_CR, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, 8'h44, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, tcle_pkg::CH_NL, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_PUT, 8'h45, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_CLEAR, 8'd0, 8'd0, 11'd0);
      send_key(tcle_pkg::REQ_CLEAR, 8'd0, 8'd0, 11'd0);
      send_key(3'd5, 8'd0, 8'd0, 11'd0);
      send_key(3'd6, 8'd0, 8'd0, 11'd0);
      send_key(3'd7, 8'hff, 8'hff, 11'h7ff);

      set_regs(7'd0, 8'd0);
      random_keys(90);
      set_regs(7'd79, 8'hff);
      random_keys(70);
      set_regs(7'($urandom_range(0, 79)), 8'($urandom));
      random_keys(60);
      calm = 1'b1;
      random_keys(40);
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      $display("%0d requests sent over four register settings, %0d screen scrolls",
               sent, scroll_count);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/tcle_pkg.sv
rtl/tcle_front.sv
rtl/tcle_queue.sv
rtl/tcle_back.sv
rtl/text_console_line_editor.sv
rtl/tcle_checker.sv
sim/tcle_checker.sv
sim/tb.sv
